// ===== rtl/core/aesbm_pkg.sv =====
// ----------------------------------------------------------------------------
// aesbm_pkg
// shared constants, tables and byte-level functions of the aes-128 mode block
// ----------------------------------------------------------------------------
package aesbm_pkg;

  localparam int BLOCK_W = 128;
  localparam int HALF_W  = 64;
  localparam int ROUNDS  = 10;
  localparam int NUM_LANES = 4;
  localparam int LANE_W  = 32;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [MODE_W-1:0] MODE_ECB    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CBC    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CFB    = 2'd2;
  // spare code, handled like ecb
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LO  = 3'd4;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [ROUNDS] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte k of a block sits at bits [127-8k -: 8]
  function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] b, input int k);
    return b[BLOCK_W-1-8*k -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// ===== rtl/core/aesbm_lane.sv =====
// ----------------------------------------------------------------------------
// aesbm_lane
// one column of an aes round: gathers its shifted bytes, sbox and, except in the last round, mixcolumns
// ----------------------------------------------------------------------------
module aesbm_lane #(
  parameter int COL = 0
) (
  input  logic [aesbm_pkg::BLOCK_W-1:0] state_in,
  input  logic                          last_round,
  output logic [aesbm_pkg::LANE_W-1:0]  col_out
);

  logic [7:0] a [4];
  logic [7:0] all_x;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      a[r] = aesbm_pkg::SBOX[aesbm_pkg::get_byte(state_in, r + 4*((COL + r) % 4))];
    end
    all_x = a[0] ^ a[1] ^ a[2] ^ a[3];
    if (last_round) begin
      col_out = {a[0], a[1], a[2], a[3]};
    end else begin
      col_out = {a[0] ^ all_x ^ aesbm_pkg::xtime(a[0] ^ a[1]),
                 a[1] ^ all_x ^ aesbm_pkg::xtime(a[1] ^ a[2]),
                 a[2] ^ all_x ^ aesbm_pkg::xtime(a[2] ^ a[3]),
                 a[3] ^ all_x ^ aesbm_pkg::xtime(a[3] ^ a[0])};
    end
  end

endmodule

// ===== rtl/core/aesbm_round.sv =====
// ----------------------------------------------------------------------------
// aesbm_round
// four column lanes side by side, merged into one state and keyed
// ----------------------------------------------------------------------------
module aesbm_round (
  input  logic [aesbm_pkg::BLOCK_W-1:0] state_in,
  input  logic [aesbm_pkg::BLOCK_W-1:0] round_key,
  input  logic                          last_round,
  output logic [aesbm_pkg::BLOCK_W-1:0] state_out
);

  logic [aesbm_pkg::LANE_W-1:0] cols [aesbm_pkg::NUM_LANES];

  for (genvar c = 0; c < aesbm_pkg::NUM_LANES; c++) begin : g_lane
    aesbm_lane #(.COL(c)) u_lane (
      .state_in  (state_in),
      .last_round(last_round),
      .col_out   (cols[c])
    );
  end

  // merge lanes: column 0 in the top word
  always_comb begin
    for (int c = 0; c < aesbm_pkg::NUM_LANES; c++) begin
      state_out[aesbm_pkg::BLOCK_W-1-aesbm_pkg::LANE_W*c -: aesbm_pkg::LANE_W] =
        cols[c] ^ round_key[aesbm_pkg::BLOCK_W-1-aesbm_pkg::LANE_W*c -: aesbm_pkg::LANE_W];
    end
  end

endmodule

// ===== rtl/core/aesbm_key_expand.sv =====
// ----------------------------------------------------------------------------
// aesbm_key_expand
// aes-128 key schedule, recomputed from the key registers
// ----------------------------------------------------------------------------
module aesbm_key_expand (
  input  logic [aesbm_pkg::BLOCK_W-1:0] key,
  output logic [aesbm_pkg::BLOCK_W-1:0] round_keys [aesbm_pkg::ROUNDS+1]
);

  always_comb begin
    logic [31:0] w0, w1, w2, w3, t;
    round_keys[0] = key;
    for (int i = 1; i <= aesbm_pkg::ROUNDS; i++) begin
      {w0, w1, w2, w3} = round_keys[i-1];
      t  = aesbm_pkg::sub_word({w3[23:0], w3[31:24]}) ^ {aesbm_pkg::RCON[i-1], 24'h0};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      round_keys[i] = {w0, w1, w2, w3};
    end
  end

endmodule

// ===== rtl/core/aes128_block_mode_encrypt.sv =====
// ----------------------------------------------------------------------------
// aes128_block_mode_encrypt
// aes-128 encryption of 128-bit words in ecb, cbc or cfb-128 mode
// ----------------------------------------------------------------------------
// all ten rounds and the key schedule are unrolled between the input and the
// output register, so chaining closes there; throughput: one word per cycle
// while the output is not stalled
// reset: rst clears mode, key, iv, chain and the output valid
// ----------------------------------------------------------------------------
module aes128_block_mode_encrypt (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // block_hi[63:0], block_lo[127:64]
  input  logic         s_tuser,  // first_block
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // cipher_hi[63:0], cipher_lo[127:64]
  input  logic         cfg_we,
  input  logic [aesbm_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [63:0]  cfg_wdata
);

  localparam int BW = aesbm_pkg::BLOCK_W;
  localparam int HW = aesbm_pkg::HALF_W;

  logic [aesbm_pkg::MODE_W-1:0] mode;
  logic [BW-1:0] key, iv, chain;
  logic [BW-1:0] round_keys [aesbm_pkg::ROUNDS+1];
  logic [BW-1:0] st [aesbm_pkg::ROUNDS+1];
  logic [BW-1:0] plain, chain_cur, aes_in, cipher;
  logic          take;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= aesbm_pkg::MODE_ECB;
      key  <= '0;
      iv   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        aesbm_pkg::REG_MODE:   mode <= cfg_wdata[aesbm_pkg::MODE_W-1:0];
        aesbm_pkg::REG_KEY_HI: key[BW-1:HW] <= cfg_wdata;
        aesbm_pkg::REG_KEY_LO: key[HW-1:0] <= cfg_wdata;
        aesbm_pkg::REG_IV_HI:  iv[BW-1:HW] <= cfg_wdata;
        aesbm_pkg::REG_IV_LO:  iv[HW-1:0] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  aesbm_key_expand u_key (.key(key), .round_keys(round_keys));

  // block_hi sits in the low half of tdata; byte 0 goes to bit 127
  assign plain     = {s_tdata[HW-1:0], s_tdata[BW-1:HW]};
  assign chain_cur = s_tuser ? iv : chain;

  always_comb begin
    case (mode)
      aesbm_pkg::MODE_CBC: aes_in = plain ^ chain_cur;
      aesbm_pkg::MODE_CFB: aes_in = chain_cur;
      default:             aes_in = plain;
    endcase
  end

  assign st[0] = aes_in ^ round_keys[0];
  for (genvar r = 1; r <= aesbm_pkg::ROUNDS; r++) begin : g_rnd
    aesbm_round u_round (
      .state_in  (st[r-1]),
      .round_key (round_keys[r]),
      .last_round(r == aesbm_pkg::ROUNDS),
      .state_out (st[r])
    );
  end

  assign cipher   = (mode == aesbm_pkg::MODE_CFB) ? (st[aesbm_pkg::ROUNDS] ^ plain)
                                                  : st[aesbm_pkg::ROUNDS];
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        if (mode == aesbm_pkg::MODE_CBC || mode == aesbm_pkg::MODE_CFB) begin
          chain <= cipher;
        end else begin
          chain <= chain_cur;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {cipher[HW-1:0], cipher[BW-1:HW]};
    end
  end

endmodule

// ===== rtl/core/aesbm_checker.sv =====
// ----------------------------------------------------------------------------
// aesbm_checker
// port-level checks of the aes mode block
// ----------------------------------------------------------------------------
module aesbm_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  a_valid_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid) else $error("no word after accept");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("stalled with empty output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid) else $error("valid after reset");

endmodule

bind aes128_block_mode_encrypt aesbm_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
